// File: sv/bwl_pkg.sv
package bwl_pkg;

  localparam int unsigned MAX_LEVELS_DEF     = 8;
  localparam int unsigned MEMORY_DEPTH_DEF   = 4096;
  localparam int unsigned MAX_LOG_LENGTH_DEF = 12;

  localparam int unsigned DATA_W    = 32;
  localparam int unsigned WADDR_W   = 12;
  localparam int unsigned LOG_IN_W  = 4;
  localparam int unsigned CFG_W     = 4;
  localparam int unsigned ACTION_W  = 2;

  localparam logic [DATA_W-1:0] PHASE_OFFSET = 32'h8000_0000;
  localparam logic [CFG_W-1:0]  NUM_LEVELS_RESET = 4'd1;

  typedef enum logic [ACTION_W-1:0] {
    ACT_LOOKUP = 2'd0,
    ACT_WORD   = 2'd1,
    ACT_DESC   = 2'd2,
    ACT_NONE   = 2'd3
  } action_e;

  // commands from the controller to the datapath
  typedef struct packed {
    logic cfg_write;
    logic capture;
    logic write_word;
    logic write_desc;
    logic select;
    logic read;
  } dp_cmd_t;

endpackage

// File: sv/bwl_ctrl.sv
module bwl_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [bwl_pkg::ACTION_W-1:0]  action_i,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  output logic                          busy_o,
  output logic                          result_valid_o,
  output bwl_pkg::dp_cmd_t              cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SELECT,
    S_READ
  } state_e;

  state_e state_q;
  logic   valid_q;
  logic   accept;

  assign busy_o         = (state_q != S_IDLE);
  assign cfg_ready_o    = !busy_o;
  assign accept         = start_i && !busy_o;
  assign result_valid_o = valid_q;

  always_comb begin
    cmd_o            = '0;
    cmd_o.cfg_write  = cfg_valid_i && cfg_ready_o;
    cmd_o.capture    = accept && (action_i == bwl_pkg::ACT_LOOKUP);
    cmd_o.write_word = accept && (action_i == bwl_pkg::ACT_WORD);
    cmd_o.write_desc = accept && (action_i == bwl_pkg::ACT_DESC);
    cmd_o.select     = (state_q == S_SELECT);
    cmd_o.read       = (state_q == S_READ);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      valid_q <= 1'b0;
    end else begin
      valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (accept && (action_i == bwl_pkg::ACT_LOOKUP)) begin
            state_q <= S_SELECT;
          end
        end
        S_SELECT: begin
          state_q <= S_READ;
        end
        S_READ: begin
          state_q <= S_IDLE;
          valid_q <= 1'b1;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: sv/bwl_datapath.sv
module bwl_datapath #(
  parameter int unsigned MAX_LEVELS     = bwl_pkg::MAX_LEVELS_DEF,
  parameter int unsigned MEMORY_DEPTH   = bwl_pkg::MEMORY_DEPTH_DEF,
  parameter int unsigned MAX_LOG_LENGTH = bwl_pkg::MAX_LOG_LENGTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  bwl_pkg::dp_cmd_t                    cmd_i,
  input  logic [bwl_pkg::CFG_W-1:0]           cfg_data_i,
  input  logic signed [bwl_pkg::DATA_W-1:0]   signal_i,
  input  logic [bwl_pkg::WADDR_W-1:0]         write_address_i,
  input  logic signed [bwl_pkg::DATA_W-1:0]   write_word_i,
  input  logic [bwl_pkg::DATA_W-1:0]          write_threshold_i,
  input  logic [bwl_pkg::LOG_IN_W-1:0]        write_log_length_i,
  output logic signed [bwl_pkg::DATA_W-1:0]   sample_o,
  output logic                                silent_o
);

  // the user must keep memory depth a power of two; the block itself does no check, and addresses wrap by truncation
  localparam int unsigned ADDR_W = $clog2(MEMORY_DEPTH);
  localparam int unsigned LVL_W  = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
  localparam int unsigned LOG_W  = $clog2(MAX_LOG_LENGTH + 1);
  localparam int unsigned CMP_W  = (LOG_W > bwl_pkg::LOG_IN_W) ? LOG_W : bwl_pkg::LOG_IN_W;
  localparam int unsigned SH_W   = $clog2(bwl_pkg::DATA_W) + 1;

  logic [bwl_pkg::CFG_W-1:0]   num_levels_q;
  logic [bwl_pkg::DATA_W-1:0]  prev_q;
  logic [bwl_pkg::DATA_W-1:0]  sig_q;
  logic [bwl_pkg::DATA_W-1:0]  step_q;
  logic [bwl_pkg::DATA_W-1:0]  thr_q [MAX_LEVELS];
  logic [LOG_W-1:0]            log_q [MAX_LEVELS];
  logic [ADDR_W-1:0]           addr_q;
  logic [ADDR_W-1:0]           addr_d;
  logic                        silent_q;
  logic                        silent_d;
  logic                        silent_out_q;
  logic [bwl_pkg::DATA_W-1:0]  rdata_q;
  logic [bwl_pkg::DATA_W-1:0]  mem [MEMORY_DEPTH];

  logic [bwl_pkg::DATA_W-1:0]  diff;
  logic [bwl_pkg::DATA_W-1:0]  step_d;
  logic [LOG_W-1:0]            log_sat;

  always_comb begin
    diff   = prev_q - signal_i;
    step_d = diff[bwl_pkg::DATA_W-1] ? (~diff + 1'b1) : diff;
    if (CMP_W'(write_log_length_i) > CMP_W'(MAX_LOG_LENGTH)) begin
      log_sat = LOG_W'(MAX_LOG_LENGTH);
    end else begin
      log_sat = LOG_W'(write_log_length_i);
    end
  end

  // first qualifying level, with the running start of its table
  always_comb begin
    logic              found;
    logic [ADDR_W-1:0] acc;
    logic [ADDR_W-1:0] start;
    logic [LOG_W-1:0]  sel_log;
    logic [bwl_pkg::DATA_W-1:0] off;
    logic [bwl_pkg::DATA_W-1:0] idx;
    found   = 1'b0;
    acc     = '0;
    start   = '0;
    sel_log = '0;
    for (int i = 0; i < MAX_LEVELS; i++) begin
      if (!found && ((i == 0) || (i < int'(num_levels_q))) && (thr_q[i] >= step_q)) begin
        found   = 1'b1;
        start   = acc;
        sel_log = log_q[i];
      end
      acc = acc + (ADDR_W'(1) << log_q[i]);
    end
    off = sig_q ^ bwl_pkg::PHASE_OFFSET;
    if (sel_log == '0) begin
      idx = '0;
    end else begin
      idx = off >> (SH_W'(bwl_pkg::DATA_W) - SH_W'(sel_log));
    end
    addr_d   = start + idx[ADDR_W-1:0];
    silent_d = !found;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_levels_q <= bwl_pkg::NUM_LEVELS_RESET;
      prev_q       <= '0;
    end else begin
      if (cmd_i.cfg_write) begin
        num_levels_q <= cfg_data_i;
      end
      if (cmd_i.capture) begin
        prev_q <= signal_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      sig_q  <= signal_i;
      step_q <= step_d;
    end
    if (cmd_i.write_desc && (write_address_i < bwl_pkg::WADDR_W'(MAX_LEVELS))) begin
      thr_q[write_address_i[LVL_W-1:0]] <= write_threshold_i;
      log_q[write_address_i[LVL_W-1:0]] <= log_sat;
    end
    if (cmd_i.select) begin
      addr_q   <= addr_d;
      silent_q <= silent_d;
    end
    if (cmd_i.read) begin
      silent_out_q <= silent_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.write_word) begin
      mem[ADDR_W'(write_address_i)] <= write_word_i;
    end
    if (cmd_i.read) begin
      rdata_q <= mem[addr_q];
    end
  end

  assign sample_o = silent_out_q ? '0 : rdata_q;
  assign silent_o = silent_out_q;

endmodule

// File: sv/bandlimited_wavetable_lookup.sv
// Mipmapped wavetable lookup. A start beat with action lookup returns one result;
// table-word and level-descriptor writes return none. A lookup holds busy after
// acceptance through level select, then the registered read of the table memory,
// so a new lookup is taken only once the last one is through those states; the
// result appears on sample_o/silent_o with result_valid_o high for exactly one cycle,
// registered from the table memory as the read state ends. The result cannot be stalled:
// sample it in that cycle. The level count is written on the cfg port while idle.
// MEMORY_DEPTH must be a power of two. Descriptors and table words must be written
// before a lookup reads them.
module bandlimited_wavetable_lookup #(
  parameter int unsigned MAX_LEVELS     = bwl_pkg::MAX_LEVELS_DEF,
  parameter int unsigned MEMORY_DEPTH   = bwl_pkg::MEMORY_DEPTH_DEF,
  parameter int unsigned MAX_LOG_LENGTH = bwl_pkg::MAX_LOG_LENGTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic [bwl_pkg::ACTION_W-1:0]        action_i,
  input  logic signed [bwl_pkg::DATA_W-1:0]   signal_i,
  input  logic [bwl_pkg::WADDR_W-1:0]         write_address_i,
  input  logic signed [bwl_pkg::DATA_W-1:0]   write_word_i,
  input  logic [bwl_pkg::DATA_W-1:0]          write_threshold_i,
  input  logic [bwl_pkg::LOG_IN_W-1:0]        write_log_length_i,
  output logic signed [bwl_pkg::DATA_W-1:0]   sample_o,
  output logic                                silent_o,
  output logic                                result_valid_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [bwl_pkg::CFG_W-1:0]           cfg_data_i
);

  bwl_pkg::dp_cmd_t cmd;

  bwl_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start),
    .action_i       (action_i),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .busy_o         (busy),
    .result_valid_o (result_valid_o),
    .cmd_o          (cmd)
  );

  bwl_datapath #(
    .MAX_LEVELS     (MAX_LEVELS),
    .MEMORY_DEPTH   (MEMORY_DEPTH),
    .MAX_LOG_LENGTH (MAX_LOG_LENGTH)
  ) u_datapath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .cfg_data_i         (cfg_data_i),
    .signal_i           (signal_i),
    .write_address_i    (write_address_i),
    .write_word_i       (write_word_i),
    .write_threshold_i  (write_threshold_i),
    .write_log_length_i (write_log_length_i),
    .sample_o           (sample_o),
    .silent_o           (silent_o)
  );

endmodule
